/* src/assert_macros.svh */
// Assertion helpers included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/bkv_pkg.sv */
// ----------------------------------------------------------------------------
// bkv_pkg
// Shared types and codes of the knot vector builder: commands, register
// indexes, datapath operations and the status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package bkv_pkg;

    localparam int MAX_OUT = 64;
    localparam int CFG_W   = 17;
    localparam int TOL_W   = 17;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_TARGET = 2'd1;
    localparam logic [1:0] REG_TOL    = 2'd2;

    localparam logic [2:0]       DEGREE_RST = 3'd3;
    localparam logic [5:0]       TARGET_RST = 6'd8;
    localparam logic [TOL_W-1:0] TOL_RST    = 17'd655;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SETUP,
        OP_FILL_LO,
        OP_FILL_HI,
        OP_MPUSH,
        OP_CLR_MIN,
        OP_CLR_MAX,
        OP_SCAN2,
        OP_SCAN3,
        OP_SCAN4,
        OP_FETCH,
        OP_DEC2,
        OP_DEL_SETUP,
        OP_ERASE,
        OP_ERASE_END,
        OP_INS_SETUP,
        OP_INS,
        OP_INS_END,
        OP_EMIT_CLR,
        OP_EMIT_RD,
        OP_EMIT_LD
    } op_t;

    typedef struct packed {
        logic fill_last;
        logic merge_done;
        logic scan_done;
        logic elim_go;
        logic pos_zero;
        logic shift_done;
        logic ins_done;
        logic need_ins;
        logic ins_room;
        logic need_del;
        logic out_free;
        logic emit_last;
    } stat_t;

endpackage

`default_nettype wire

/* src/bkv_ctrl.sv */
// ----------------------------------------------------------------------------
// bkv_ctrl
// Sequencer of the build: steps the datapath through load, merge, close-knot
// elimination, midpoint insertion, span deletion and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module bkv_ctrl
    import bkv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] s_command,
    output logic            s_ready,
    input  wire stat_t      stat,
    output op_t             op
);

    typedef enum logic [23:0] {
        ST_IDLE      = 24'h000001,
        ST_FILL_LO   = 24'h000002,
        ST_MRD       = 24'h000004,
        ST_MDEC      = 24'h000008,
        ST_FILL_HI   = 24'h000010,
        ST_CLR2      = 24'h000020,
        ST_SCAN2     = 24'h000040,
        ST_FETCH     = 24'h000080,
        ST_DEC2      = 24'h000100,
        ST_ERASE     = 24'h000200,
        ST_ERASE_END = 24'h000400,
        ST_CHECK3    = 24'h000800,
        ST_CLR3      = 24'h001000,
        ST_SCAN3     = 24'h002000,
        ST_INS_SETUP = 24'h004000,
        ST_INS       = 24'h008000,
        ST_INS_END   = 24'h010000,
        ST_CHECK4    = 24'h020000,
        ST_CLR4      = 24'h040000,
        ST_SCAN4     = 24'h080000,
        ST_DEL_SETUP = 24'h100000,
        ST_EMIT_CLR  = 24'h200000,
        ST_EMIT_RD   = 24'h400000,
        ST_EMIT_LD   = 24'h800000
    } state_t;

    state_t state_reg, state_next;
    logic   del_phase_reg, del_phase_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        del_phase_next = del_phase_reg;
        op             = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == CMD_RUN) begin
                        op             = OP_SETUP;
                        del_phase_next = 1'b0;
                        state_next     = ST_FILL_LO;
                    end else begin
                        op = OP_LOAD;
                    end
                end
            end
            ST_FILL_LO: begin
                op = OP_FILL_LO;
                if (stat.fill_last) state_next = ST_MRD;
            end
            ST_MRD: state_next = ST_MDEC;
            ST_MDEC: begin
                if (stat.merge_done) begin
                    state_next = ST_FILL_HI;
                end else begin
                    op         = OP_MPUSH;
                    state_next = ST_MRD;
                end
            end
            ST_FILL_HI: begin
                op = OP_FILL_HI;
                if (stat.fill_last) state_next = ST_CLR2;
            end
            ST_CLR2: begin
                op         = OP_CLR_MIN;
                state_next = ST_SCAN2;
            end
            ST_SCAN2: begin
                op = OP_SCAN2;
                if (stat.scan_done) state_next = stat.elim_go ? ST_FETCH : ST_CHECK3;
            end
            ST_FETCH: begin
                op         = OP_FETCH;
                state_next = ST_DEC2;
            end
            ST_DEC2: begin
                op         = OP_DEC2;
                state_next = ST_ERASE;
            end
            ST_ERASE: begin
                op = OP_ERASE;
                if (stat.shift_done) state_next = ST_ERASE_END;
            end
            ST_ERASE_END: begin
                op         = OP_ERASE_END;
                state_next = del_phase_reg ? ST_CHECK4 : ST_CLR2;
            end
            ST_CHECK3: begin
                state_next = (stat.need_ins && stat.ins_room) ? ST_CLR3 : ST_CHECK4;
            end
            ST_CLR3: begin
                op         = OP_CLR_MAX;
                state_next = ST_SCAN3;
            end
            ST_SCAN3: begin
                op = OP_SCAN3;
                if (stat.scan_done) state_next = stat.pos_zero ? ST_CHECK4 : ST_INS_SETUP;
            end
            ST_INS_SETUP: begin
                op         = OP_INS_SETUP;
                state_next = ST_INS;
            end
            ST_INS: begin
                op = OP_INS;
                if (stat.ins_done) state_next = ST_INS_END;
            end
            ST_INS_END: begin
                op         = OP_INS_END;
                state_next = ST_CHECK3;
            end
            ST_CHECK4: begin
                del_phase_next = 1'b1;
                state_next     = stat.need_del ? ST_CLR4 : ST_EMIT_CLR;
            end
            ST_CLR4: begin
                op         = OP_CLR_MIN;
                state_next = ST_SCAN4;
            end
            ST_SCAN4: begin
                op = OP_SCAN4;
                if (stat.scan_done) state_next = ST_DEL_SETUP;
            end
            ST_DEL_SETUP: begin
                op         = OP_DEL_SETUP;
                state_next = ST_ERASE;
            end
            ST_EMIT_CLR: begin
                op         = OP_EMIT_CLR;
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                op = OP_EMIT_RD;
                if (stat.out_free) state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                op         = OP_EMIT_LD;
                state_next = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            del_phase_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            del_phase_reg <= del_phase_next;
        end
    end

endmodule

`default_nettype wire

/* src/bkv_datapath.sv */
// ----------------------------------------------------------------------------
// bkv_datapath
// Input stores, work store, scan and shift counters, configuration registers
// and the output register of the knot vector builder.
// ----------------------------------------------------------------------------
`default_nettype none

module bkv_datapath
    import bkv_pkg::*;
#(
    parameter int INPUT_DEPTH = 64,
    parameter int WORK_DEPTH  = 128,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire op_t                  op,
    output stat_t                     stat,
    input  wire logic [1:0]           s_command,
    input  wire logic [FRAC_BITS:0]   s_knot,
    input  wire logic                 cfg_valid,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic [FRAC_BITS:0]        m_knot_out,
    output logic                      m_last,
    output logic                      m_overflow
);

    localparam int KW   = FRAC_BITS + 1;
    localparam int IAW  = $clog2(INPUT_DEPTH);
    localparam int ICW  = $clog2(INPUT_DEPTH + 1);
    localparam int WAW  = $clog2(WORK_DEPTH);
    localparam int WCW  = $clog2(WORK_DEPTH + 1);
    localparam int DW   = ((KW > TOL_W) ? KW : TOL_W) + 2;
    localparam int EMAX = WORK_DEPTH / 2;
    localparam int ROOM = (MAX_OUT < WORK_DEPTH) ? MAX_OUT : WORK_DEPTH;
    localparam logic [KW-1:0] ONE_K = {1'b1, {FRAC_BITS{1'b0}}};

    // configuration
    logic [2:0]       deg_reg;
    logic [5:0]       tgt_reg;
    logic [TOL_W-1:0] tol_reg;

    // input stores
    logic [KW-1:0]  first_mem [INPUT_DEPTH];
    logic [KW-1:0]  second_mem [INPUT_DEPTH];
    logic [KW-1:0]  fq_reg, sq_reg;
    logic [ICW-1:0] fc_reg, sc_reg, i_reg, j_reg;

    // work store
    logic [KW-1:0]  wmem [WORK_DEPTH];
    logic [KW-1:0]  wq_reg;
    logic           w_we;
    logic [WAW-1:0] w_wa, w_ra;
    logic [KW-1:0]  w_wd;

    logic [WCW-1:0] wc_reg, e_reg, bound_reg, mlim_reg, cnt_reg, n_reg;
    logic [KW-1:0]  last_reg;
    logic [WCW-1:0] a_reg, qi_reg, pos_reg;
    logic           qv_reg, found_reg, ovf_reg;
    logic [KW-1:0]  p1_reg, p2_reg, mid_reg, vm_reg, vm1_reg, left_reg;
    logic signed [DW-1:0] best_reg;

    logic           m_valid_reg, m_last_reg, m_ovf_reg;
    logic [KW-1:0]  m_knot_reg;

    // combinational helpers
    logic [KW-1:0]        kv, av, bv, mv, r2;
    logic                 a_lt_b;
    logic signed [DW-1:0] d_pair, d_span, dl, dr;
    logic [KW:0]          mid_sum;
    logic [WCW:0]         pos_p2;
    logic [WCW-1:0]       e_c, erase_idx;
    int                   lim_i, tgt_i;

    assign kv      = (s_knot > ONE_K) ? ONE_K : s_knot;
    assign av      = (i_reg < fc_reg) ? fq_reg : ONE_K;
    assign bv      = (j_reg < sc_reg) ? sq_reg : ONE_K;
    assign a_lt_b  = (av < bv);
    assign mv      = a_lt_b ? av : bv;
    assign d_pair  = $signed(DW'(wq_reg)) - $signed(DW'(p1_reg));
    assign d_span  = $signed(DW'(wq_reg)) - $signed(DW'(p2_reg));
    assign mid_sum = {1'b0, p1_reg} + {1'b0, wq_reg};
    assign pos_p2  = {1'b0, pos_reg} + (WCW+1)'(2);
    assign r2      = (pos_p2 < {1'b0, wc_reg}) ? wq_reg : ONE_K;
    assign dl      = $signed(DW'(vm_reg)) - $signed(DW'(left_reg));
    assign dr      = $signed(DW'(r2)) - $signed(DW'(vm1_reg));
    assign erase_idx = ((vm_reg == '0) || ((dl < dr) && (vm1_reg != ONE_K)))
                       ? pos_reg + WCW'(1) : pos_reg;

    // end-knot count and target clamp, taken at run start
    always_comb begin
        if (int'(deg_reg) + 1 > EMAX) e_c = WCW'(EMAX);
        else                          e_c = WCW'(deg_reg) + WCW'(1);
        lim_i = ROOM - 2 * int'(e_c);
        tgt_i = (int'(tgt_reg) > lim_i) ? lim_i : int'(tgt_reg);
    end

    // status
    always_comb begin
        stat.fill_last  = (cnt_reg == e_reg - WCW'(1));
        stat.merge_done = !((av < ONE_K) || (bv < ONE_K));
        stat.scan_done  = (a_reg >= wc_reg) && !qv_reg;
        stat.elim_go    = found_reg && !(best_reg > $signed(DW'(tol_reg)));
        stat.pos_zero   = (pos_reg == '0);
        stat.shift_done = (a_reg >= wc_reg) && !qv_reg;
        stat.ins_done   = (a_reg <= pos_reg) && !qv_reg;
        stat.need_ins   = (wc_reg < bound_reg);
        stat.ins_room   = (wc_reg < WCW'(WORK_DEPTH));
        stat.need_del   = (wc_reg > bound_reg);
        stat.out_free   = !m_valid_reg || m_ready;
        stat.emit_last  = (a_reg + WCW'(1) == n_reg);
    end

    // work store port selection
    always_comb begin
        w_we = 1'b0;
        w_wa = wc_reg[WAW-1:0];
        w_wd = '0;
        w_ra = a_reg[WAW-1:0];
        case (op)
            OP_FILL_LO: w_we = 1'b1;
            OP_FILL_HI: begin
                w_we = 1'b1;
                w_wd = ONE_K;
            end
            OP_MPUSH: begin
                w_we = (mv != last_reg) && (wc_reg < mlim_reg);
                w_wd = mv;
            end
            OP_FETCH: w_ra = pos_p2[WAW-1:0];
            OP_ERASE: begin
                w_we = qv_reg;
                w_wa = WAW'(qi_reg - WCW'(1));
                w_wd = wq_reg;
            end
            OP_INS: begin
                w_ra = WAW'(a_reg - WCW'(1));
                w_we = qv_reg;
                w_wa = WAW'(qi_reg + WCW'(1));
                w_wd = wq_reg;
            end
            OP_INS_END: begin
                w_we = 1'b1;
                w_wa = pos_reg[WAW-1:0];
                w_wd = mid_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (w_we) wmem[w_wa] <= w_wd;
        wq_reg <= wmem[w_ra];
        fq_reg <= first_mem[i_reg[IAW-1:0]];
        sq_reg <= second_mem[j_reg[IAW-1:0]];
        if (op == OP_LOAD && s_command == CMD_LOAD_A && fc_reg < ICW'(INPUT_DEPTH))
            first_mem[fc_reg[IAW-1:0]] <= kv;
        if (op == OP_LOAD && s_command == CMD_LOAD_B && sc_reg < ICW'(INPUT_DEPTH))
            second_mem[sc_reg[IAW-1:0]] <= kv;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deg_reg <= DEGREE_RST;
            tgt_reg <= TARGET_RST;
            tol_reg <= TOL_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEGREE: deg_reg <= cfg_wdata[2:0];
                REG_TARGET: tgt_reg <= cfg_wdata[5:0];
                REG_TOL:    tol_reg <= cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // control-side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fc_reg      <= '0;
            sc_reg      <= '0;
            wc_reg      <= '0;
            ovf_reg     <= 1'b0;
            qv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && op != OP_EMIT_LD) m_valid_reg <= 1'b0;
            case (op)
                OP_LOAD: begin
                    if (s_command == CMD_LOAD_A) begin
                        if (fc_reg < ICW'(INPUT_DEPTH)) fc_reg <= fc_reg + ICW'(1);
                        else                            ovf_reg <= 1'b1;
                    end else if (s_command == CMD_LOAD_B) begin
                        if (sc_reg < ICW'(INPUT_DEPTH)) sc_reg <= sc_reg + ICW'(1);
                        else                            ovf_reg <= 1'b1;
                    end
                end
                OP_SETUP: begin
                    wc_reg <= '0;
                    if (int'(tgt_reg) > lim_i) ovf_reg <= 1'b1;
                end
                OP_FILL_LO, OP_FILL_HI: wc_reg <= wc_reg + WCW'(1);
                OP_MPUSH: begin
                    if (mv != last_reg) begin
                        if (wc_reg < mlim_reg) wc_reg <= wc_reg + WCW'(1);
                        else                   ovf_reg <= 1'b1;
                    end
                end
                OP_CLR_MIN, OP_CLR_MAX, OP_DEC2, OP_DEL_SETUP, OP_INS_SETUP:
                    qv_reg <= 1'b0;
                OP_SCAN2, OP_SCAN3, OP_SCAN4, OP_ERASE: qv_reg <= (a_reg < wc_reg);
                OP_INS: qv_reg <= (a_reg > pos_reg);
                OP_ERASE_END: wc_reg <= wc_reg - WCW'(1);
                OP_INS_END:   wc_reg <= wc_reg + WCW'(1);
                OP_EMIT_LD: begin
                    m_valid_reg <= 1'b1;
                    if (stat.emit_last) begin
                        fc_reg  <= '0;
                        sc_reg  <= '0;
                        ovf_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (op)
            OP_SETUP: begin
                e_reg     <= e_c;
                mlim_reg  <= WCW'(WORK_DEPTH) - e_c;
                bound_reg <= WCW'(2 * int'(e_c) + tgt_i);
                cnt_reg   <= '0;
                i_reg     <= '0;
                j_reg     <= '0;
                last_reg  <= '0;
            end
            OP_FILL_LO, OP_FILL_HI: begin
                if (stat.fill_last) cnt_reg <= '0;
                else                cnt_reg <= cnt_reg + WCW'(1);
            end
            OP_MPUSH: begin
                if (mv != last_reg && wc_reg < mlim_reg) last_reg <= mv;
                if (a_lt_b) i_reg <= i_reg + ICW'(1);
                else        j_reg <= j_reg + ICW'(1);
            end
            OP_CLR_MIN, OP_CLR_MAX: begin
                a_reg     <= '0;
                found_reg <= 1'b0;
                pos_reg   <= '0;
                best_reg  <= (op == OP_CLR_MIN) ? $signed(DW'(ONE_K)) : '0;
            end
            OP_SCAN2, OP_SCAN3, OP_SCAN4: begin
                if (a_reg < wc_reg) a_reg <= a_reg + WCW'(1);
                qi_reg <= a_reg;
                if (qv_reg) begin
                    p1_reg <= wq_reg;
                    p2_reg <= p1_reg;
                    if (op == OP_SCAN2) begin
                        if (qi_reg >= WCW'(1) && p1_reg != wq_reg && d_pair < best_reg) begin
                            best_reg  <= d_pair;
                            pos_reg   <= qi_reg - WCW'(1);
                            found_reg <= 1'b1;
                            vm_reg    <= p1_reg;
                            vm1_reg   <= wq_reg;
                            left_reg  <= (qi_reg >= WCW'(2)) ? p2_reg : '0;
                        end
                    end else if (op == OP_SCAN3) begin
                        if (qi_reg >= WCW'(1) && d_pair > best_reg) begin
                            best_reg <= d_pair;
                            pos_reg  <= qi_reg;
                            mid_reg  <= mid_sum[KW:1];
                        end
                    end else begin
                        if (qi_reg >= WCW'(2) && p2_reg != wq_reg && d_span < best_reg) begin
                            best_reg <= d_span;
                            pos_reg  <= qi_reg - WCW'(1);
                        end
                    end
                end
            end
            OP_DEC2:      a_reg <= erase_idx + WCW'(1);
            OP_DEL_SETUP: a_reg <= pos_reg + WCW'(1);
            OP_ERASE: begin
                if (a_reg < wc_reg) a_reg <= a_reg + WCW'(1);
                qi_reg <= a_reg;
            end
            OP_INS_SETUP: a_reg <= wc_reg;
            OP_INS: begin
                if (a_reg > pos_reg) a_reg <= a_reg - WCW'(1);
                qi_reg <= a_reg - WCW'(1);
            end
            OP_EMIT_CLR: begin
                a_reg <= '0;
                n_reg <= (wc_reg > WCW'(ROOM)) ? WCW'(ROOM) : wc_reg;
            end
            OP_EMIT_LD: begin
                a_reg      <= a_reg + WCW'(1);
                m_knot_reg <= wq_reg;
                m_last_reg <= stat.emit_last;
                m_ovf_reg  <= ovf_reg;
            end
            default: ;
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_knot_out = m_knot_reg;
    assign m_last     = m_last_reg;
    assign m_overflow = m_ovf_reg;

endmodule

`default_nettype wire

/* src/bspline_knot_vector_builder_core.sv */
// ----------------------------------------------------------------------------
// bspline_knot_vector_builder_core
// Builds a clamped B-spline knot vector from two loaded knot vectors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): each beat carries a command and a knot. Load beats
//   (first or second vector) are taken one per cycle while the block is idle
//   and produce no output; a load past INPUT_DEPTH is dropped and flagged.
//   A run beat starts the build: merge, close-knot elimination, midpoint
//   insertion and span deletion, then the vector is sent on m_* one knot per
//   beat, m_last on the final knot, m_overflow on every beat of a run that
//   saw a capacity exceeded. s_ready stays low for the whole run.
//   Run steps: the low end knots are written, each merge step reads both
//   input stores and then pushes the smaller knot, the high end knots
//   follow; every elimination, insertion or deletion costs one scan of
//   the work store plus a shift pass over the knots behind the changed
//   slot, and a last scan closes the elimination phase; then each beat
//   is read and loaded. The single read port of the work store sets this order.
//   Output stall: a beat waits in the output register while m_ready is low;
//   the next knot is read only once that register frees. After the last
//   beat is loaded the block is idle again and takes loads at once.
//   Configuration (cfg_*) is always ready; it must be written while idle, which the block does not enforce.
//   Reset (aresetn low, synchronous) empties both input vectors, clears the
//   overflow flag and returns registers to degree 3, target 8, tolerance 655.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bspline_knot_vector_builder_core
    import bkv_pkg::*;
#(
    parameter int INPUT_DEPTH = 64,
    parameter int WORK_DEPTH  = 128,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input beats
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_command,
    input  wire logic [FRAC_BITS:0] s_knot,
    // result beats
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [FRAC_BITS:0]      m_knot_out,
    output logic                    m_last,
    output logic                    m_overflow,
    // configuration writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wdata
);

    op_t   op;
    stat_t stat;

    // registers accept every write; software must write only while idle, which is not enforced here
    assign cfg_ready = 1'b1;

    bkv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .op        (op)
    );

    bkv_datapath #(
        .INPUT_DEPTH (INPUT_DEPTH),
        .WORK_DEPTH  (WORK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .stat       (stat),
        .s_command  (s_command),
        .s_knot     (s_knot),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_knot_out (m_knot_out),
        .m_last     (m_last),
        .m_overflow (m_overflow)
    );

    // a run beat closes the input until the last knot is loaded
    `ASSERT_NEXT(a_run_closes_input, aclk, aresetn, s_valid && s_ready && s_command == CMD_RUN, !s_ready)
    // input stays closed while non-final knots are pending
    `ASSERT_IMPL(a_busy_while_emitting, aclk, aresetn, m_valid && !m_last, !s_ready)
    // load beats never raise a result
    `ASSERT_NEXT(a_load_no_result, aclk, aresetn, s_valid && s_ready && s_command != CMD_RUN && !m_valid, !m_valid)

endmodule

`default_nettype wire

/* bench/bspline_knot_vector_builder_core_tb.sv */
// ----------------------------------------------------------------------------
// bspline_knot_vector_builder_core_tb
// Self-checking bench: loads knot vectors, runs builds under several register
// settings and compares every output beat against a local model of the build.
// ----------------------------------------------------------------------------
module bspline_knot_vector_builder_core_tb;
    import bkv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  IN_DEPTH   = 64;
    localparam int  WORK_SLOTS = 128;
    localparam int  FB         = 16;
    localparam longint ONE_FX  = longint'(1) << FB;
    localparam int  STALL_CAP  = 200000;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [FB:0] knot;
        logic        last;
        logic        ovf;
    } knot_beat_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [FB:0] knot;
        bit          frame_only;   // result is just the clamped end knots
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_command = CMD_LOAD_A;
    logic [FB:0]       s_knot = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [FB:0]       m_knot_out;
    logic              m_last;
    logic              m_overflow;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = REG_DEGREE;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    bspline_knot_vector_builder_core i_dut (.*);

    always #10 aclk = ~aclk;

    // Local copy of the block state and registers
    longint     knots_a [IN_DEPTH];
    longint     knots_b [IN_DEPTH];
    int         cnt_a, cnt_b;
    bit         ovf_seen;
    int         reg_degree = 3;
    int         reg_target = 8;
    longint     reg_tol = 655;

    knot_beat_t pending_knots[$];
    knot_beat_t built[$];
    int         errors = 0;
    bit         calm = 0;          // no idling on either side while set
    int         quiet_cycles = 0;

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    // Build the combined vector for a run; results land in built
    function automatic void build_vector();
        longint     w [WORK_SLOTS];
        int         wc, e, lim, tgt, i, j, k, mi, mx, mn;
        longint     av, bv, best, d, dl, dr, left, r1, r2;
        bit         found;
        knot_beat_t beat;
        e = reg_degree + 1;
        if (e > WORK_SLOTS / 2) e = WORK_SLOTS / 2;
        lim = MAX_OUT - 2 * e;
        tgt = reg_target;
        if (tgt > lim) begin
            tgt = lim;
            ovf_seen = 1;
        end
        wc = 0;
        for (k = 0; k < e; k++) w[wc++] = 0;
        i = 0;
        j = 0;
        while (1) begin
            av = (i < cnt_a) ? knots_a[i] : ONE_FX;
            bv = (j < cnt_b) ? knots_b[j] : ONE_FX;
            if (!(av < ONE_FX || bv < ONE_FX)) break;
            if (av < bv) i++;
            else begin
                av = bv;
                j++;
            end
            if (!(wc > 0 && av == w[wc-1])) begin
                if (wc < WORK_SLOTS - e) w[wc++] = av;
                else ovf_seen = 1;
            end
        end
        for (k = 0; k < e; k++) w[wc++] = ONE_FX;
        // drop close knots
        while (1) begin
            best = ONE_FX;
            mi = 0;
            found = 0;
            for (k = 1; k < wc; k++)
                if (w[k-1] != w[k]) begin
                    d = w[k] - w[k-1];
                    if (d < best) begin
                        best = d;
                        mi = k - 1;
                        found = 1;
                    end
                end
            if (!found || best > reg_tol) break;
            left = (mi > 0) ? w[mi-1] : 0;
            r1 = (mi + 1 < wc) ? w[mi+1] : ONE_FX;
            r2 = (mi + 2 < wc) ? w[mi+2] : ONE_FX;
            dl = w[mi] - left;
            dr = r2 - r1;
            if (w[mi] == 0 || (dl < dr && r1 != ONE_FX)) mi = mi + 1;
            if (mi < wc) begin
                for (k = mi; k < wc - 1; k++) w[k] = w[k+1];
                wc--;
            end
        end
        // split the widest interval
        while (wc - 2 * e < tgt) begin
            best = 0;
            mx = 0;
            for (k = 1; k < wc; k++) begin
                d = w[k] - w[k-1];
                if (d > best) begin
                    best = d;
                    mx = k;
                end
            end
            if (mx == 0 || wc >= WORK_SLOTS) break;
            for (k = wc; k > mx; k--) w[k] = w[k-1];
            w[mx] = (w[mx-1] + w[mx+1]) >> 1;
            wc++;
        end
        // remove the knot with the narrowest span
        while (wc - 2 * e > tgt) begin
            best = ONE_FX;
            mn = 0;
            for (k = 1; k + 1 < wc; k++)
                if (w[k-1] != w[k+1]) begin
                    d = w[k+1] - w[k-1];
                    if (d < best) begin
                        best = d;
                        mn = k;
                    end
                end
            for (k = mn; k < wc - 1; k++) w[k] = w[k+1];
            wc--;
        end
        if (wc > MAX_OUT) wc = MAX_OUT;
        built.delete();
        for (k = 0; k < wc; k++) begin
            beat = '{w[k][FB:0], (k + 1 == wc), ovf_seen};
            built = {built, beat};
        end
        cnt_a = 0;
        cnt_b = 0;
        ovf_seen = 0;
    endfunction

    function automatic void track_item(input logic [1:0] cmd, input logic [FB:0] kin);
        longint kv;
        kv = kin;
        if (kv > ONE_FX) kv = ONE_FX;
        built.delete();
        case (cmd)
            CMD_LOAD_A: begin
                if (cnt_a < IN_DEPTH) knots_a[cnt_a++] = kv;
                else ovf_seen = 1;
            end
            CMD_LOAD_B: begin
                if (cnt_b < IN_DEPTH) knots_b[cnt_b++] = kv;
                else ovf_seen = 1;
            end
            CMD_RUN: build_vector();
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one beat, hold until taken, then predict its results
    task automatic send_beat(input logic [1:0] cmd, input logic [FB:0] kin,
                             input bit frame_only);
        int         gap, k, e;
        knot_beat_t beat;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_knot    <= kin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        e = reg_degree + 1;
        track_item(cmd, kin);
        if (frame_only) begin
            for (k = 0; k < 2 * e; k++) begin
                beat = '{(k < e) ? '0 : ONE_FX[FB:0], (k == 2 * e - 1), 1'b0};
                pending_knots = {pending_knots, beat};
            end
        end else begin
            pending_knots = {pending_knots, built};
        end
    endtask

    // Wait out outstanding beats, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_knots.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DEGREE: reg_degree = value & 7;
            REG_TARGET: reg_target = value & 63;
            default:    reg_tol = value & 32'h1FFFF;
        endcase
    endtask

    // One build: non-decreasing knots into both vectors, an optional noise beat, then run
    task automatic random_build();
        int     na, nb, k;
        longint v;
        na = $urandom_range(0, 7);
        nb = $urandom_range(0, 5);
        v = 0;
        for (k = 0; k < na; k++) begin
            v += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 900)
                                             : $urandom_range(1, 14000);
            if (v > ONE_FX) v = ONE_FX;
            send_beat(CMD_LOAD_A, v[FB:0], 1'b0);
        end
        v = 0;
        for (k = 0; k < nb; k++) begin
            v += $urandom_range(0, 20000);
            if (v > ONE_FX) v = ONE_FX;
            send_beat(CMD_LOAD_B, v[FB:0], 1'b0);
        end
        // noise: any command, any knot bits
        if ($urandom_range(0, 3) == 0)
            send_beat(2'($urandom_range(0, 3)), 17'($urandom_range(0, 131071)), 1'b0);
        send_beat(CMD_RUN, 17'($urandom_range(0, 131071)), 1'b0);
    endtask

    stim_row_t directed [] = '{
        '{CMD_RUN,    17'd0,      1},   // empty vectors: end knots only
        '{CMD_LOAD_A, 17'd0,      0},   // duplicate zero is dropped
        '{CMD_LOAD_A, 17'd65536,  0},
        '{CMD_LOAD_B, 17'h1FFFF,  0},   // above one saturates
        '{CMD_RUN,    17'h1FFFF,  0},
        '{CMD_SPARE,  17'd12345,  0},   // spare command is ignored
        '{CMD_LOAD_A, 17'd40000,  0},   // unsorted input
        '{CMD_LOAD_A, 17'd10000,  0},
        '{CMD_RUN,    17'd0,      0},
        '{CMD_LOAD_A, 17'd30000,  0},   // no closing one
        '{CMD_LOAD_B, 17'd30000,  0},
        '{CMD_RUN,    17'd0,      0},
        '{CMD_LOAD_A, 17'd1000,   0},   // close pair
        '{CMD_LOAD_A, 17'd1200,   0},
        '{CMD_LOAD_B, 17'd64900,  0},
        '{CMD_RUN,    17'd0,      0}
    };

    // Result side: random back-pressure, then check each beat
    int ready_hold = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready    <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
            ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        knot_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_knots.size() == 0) begin
                report($sformatf("unexpected beat knot=%0d", m_knot_out));
            end else begin
                want = pending_knots.pop_front();
                if (m_knot_out !== want.knot)
                    report($sformatf("knot_out %0d, want %0d", m_knot_out, want.knot));
                if (m_last !== want.last)
                    report($sformatf("last %0b, want %0b", m_last, want.last));
                if (m_overflow !== want.ovf)
                    report($sformatf("overflow %0b, want %0b", m_overflow, want.ovf));
            end
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int k;
        cnt_a = 0;
        cnt_b = 0;
        ovf_seen = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows at zero target so the empty run is just end knots
        write_reg(REG_TARGET, 0);
        foreach (directed[row])
            send_beat(directed[row].cmd, directed[row].knot, directed[row].frame_only);
        drain();

        // Reset defaults, then extremes and a mix
        write_reg(REG_TARGET, 8);
        repeat (2) random_build();
        drain();

        write_reg(REG_DEGREE, 1);
        write_reg(REG_TARGET, 0);
        write_reg(REG_TOL, 0);
        calm = 1;
        random_build();
        calm = 0;
        drain();

        write_reg(REG_DEGREE, 7);
        write_reg(REG_TARGET, 48);
        write_reg(REG_TOL, 65536);
        repeat (2) random_build();
        drain();

        write_reg(REG_DEGREE, 5);
        write_reg(REG_TARGET, 20);
        write_reg(REG_TOL, 3000);
        random_build();
        drain();

        // Overfill the first vector, target above the limit
        write_reg(REG_DEGREE, 1);
        write_reg(REG_TARGET, 63);
        write_reg(REG_TOL, 0);
        for (k = 0; k < 65; k++) send_beat(CMD_LOAD_A, 17'(k * 1000 + 1), 1'b0);
        send_beat(CMD_RUN, 17'd0, 1'b0);
        drain();

        write_reg(REG_DEGREE, 2);
        write_reg(REG_TARGET, 12);
        write_reg(REG_TOL, 655);
        random_build();
        drain();

        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
